FILE: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int FIELD_WIDTH  = 16;
   localparam int STATUS_WIDTH = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOMEM   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNKNOWN = 2'd2;

   // search token control travelling along the row of cells
   typedef struct packed {
      logic active;
      logic found;
   } tok_ctl_type;

endpackage

FILE: rtl/ffa_ifs.sv
// ----------------------------------------------------------------------------
// ffa_ifs
// Request and response channels of the first-fit block allocator.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   import ffa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [FIELD_WIDTH-1:0] request_size;
   logic [FIELD_WIDTH-1:0] free_address;

   modport source (output valid, output opcode, output request_size,
                   output free_address, input ready);
   modport sink   (input valid, input opcode, input request_size,
                   input free_address, output ready);
endinterface

interface ffa_rsp_if;
   import ffa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FIELD_WIDTH-1:0]  address;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, output address, output status, input ready);
   modport sink   (input valid, input address, input status, output ready);
endinterface

FILE: rtl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One table entry of the allocator: holds a block and checks the passing
// search token against it.
// ----------------------------------------------------------------------------
module ffa_cell #(
   parameter int IDX         = 0,
   parameter int ADDR_WIDTH  = 16,
   parameter int COUNT_WIDTH = 5,
   parameter int INDEX_WIDTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    op,
   input  logic [ADDR_WIDTH-1:0]   req_size,
   input  logic [ADDR_WIDTH-1:0]   req_addr,
   input  logic [COUNT_WIDTH-1:0]  entry_count,
   input  logic                    wr_en,
   input  logic [INDEX_WIDTH-1:0]  wr_idx,
   input  logic [ADDR_WIDTH-1:0]   wr_base,
   input  logic [ADDR_WIDTH-1:0]   wr_size,
   input  ffa_pkg::tok_ctl_type    tok_ctl_i,
   input  logic [ADDR_WIDTH-1:0]   tok_base_i,
   output ffa_pkg::tok_ctl_type    tok_ctl_o,
   output logic [ADDR_WIDTH-1:0]   tok_base_o
);
   import ffa_pkg::*;

   logic [ADDR_WIDTH-1:0] base_ff;
   logic [ADDR_WIDTH-1:0] size_ff;
   logic                  free_ff;
   tok_ctl_type           tok_ctl_ff;
   tok_ctl_type           tok_ctl_in;
   logic [ADDR_WIDTH-1:0] tok_base_ff;
   logic [ADDR_WIDTH-1:0] tok_base_in;
   logic                  in_range;
   logic                  match;
   logic                  hit;
   logic                  wr_here;

   assign in_range = entry_count > COUNT_WIDTH'(IDX);
   assign match    = (op == OP_ALLOC) ? (free_ff && (size_ff >= req_size))
                                      : (base_ff == req_addr);
   assign hit      = tok_ctl_i.active && !tok_ctl_i.found && in_range && match;
   assign wr_here  = wr_en && (wr_idx == INDEX_WIDTH'(IDX));

   always_comb begin
      tok_ctl_in.active = tok_ctl_i.active;
      tok_ctl_in.found  = tok_ctl_i.found || hit;
      tok_base_in       = hit ? base_ff : tok_base_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ctl_ff <= '0;
      end else begin
         tok_ctl_ff <= tok_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_base_ff <= tok_base_in;
      if (wr_here) begin
         base_ff <= wr_base;
         size_ff <= wr_size;
         free_ff <= 1'b0;
      end else if (hit) begin
         free_ff <= (op == OP_FREE);
      end
   end

   assign tok_ctl_o  = tok_ctl_ff;
   assign tok_base_o = tok_base_ff;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator without splitting or coalescing.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (opcode 0 allocate request_size bytes, opcode 1
// free the block at free_address); each gives exactly one item on rsp_ch
// carrying the granted address and a status (ok, out of memory or table
// full, unknown free address).
// The table lives in a row of MAX_BLOCKS cells. A search token enters the
// first cell and moves one cell per cycle; the first matching cell claims
// it. A free of address zero skips the row. One request is worked on at a
// time: req_ch.ready is high only in the idle state, so the next request
// is taken only once the response to the last one is in the output register.
// The response sits in an output register; a new request is taken while it
// waits, and a finished search holds until rsp_ch.ready frees the register.
// Reset empties the table and puts the heap top at zero; it takes effect
// at once, with no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = 16,
   parameter int ADDR_WIDTH   = 16,
   parameter int HEADER_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   ffa_req_if.sink    req_ch,
   ffa_rsp_if.source  rsp_ch
);
   import ffa_pkg::*;

   localparam int COUNT_WIDTH = $clog2(MAX_BLOCKS + 1);
   localparam int INDEX_WIDTH = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int END_WIDTH   = ADDR_WIDTH + 2;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic                     op_ff;
   logic [ADDR_WIDTH-1:0]    size_ff;
   logic [ADDR_WIDTH-1:0]    addr_ff;
   logic                     zero_free_ff;
   logic                     found_ff;
   logic [ADDR_WIDTH-1:0]    hit_base_ff;
   logic                     start_ff;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [ADDR_WIDTH-1:0]    heap_top_ff;
   logic                     rsp_valid_ff;
   logic [FIELD_WIDTH-1:0]   rsp_addr_ff;
   logic [STATUS_WIDTH-1:0]  rsp_status_ff;

   logic                     accept;
   logic                     slot_free;
   logic                     finish;
   logic [ADDR_WIDTH-1:0]    in_size;
   logic [ADDR_WIDTH-1:0]    in_addr;
   logic [END_WIDTH-1:0]     end_w;
   logic                     fits;
   logic                     table_full;
   logic                     append;
   logic [ADDR_WIDTH-1:0]    new_base;
   logic [ADDR_WIDTH-1:0]    res_addr;
   logic [STATUS_WIDTH-1:0]  res_status;

   tok_ctl_type              tok_ctl  [0:MAX_BLOCKS];
   logic [ADDR_WIDTH-1:0]    tok_base [0:MAX_BLOCKS];
   logic [MAX_BLOCKS:0]      tok_act;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign finish    = (state_ff == ST_FINISH) && slot_free;
   assign in_size   = ADDR_WIDTH'(req_ch.request_size);
   assign in_addr   = ADDR_WIDTH'(req_ch.free_address);

   assign req_ch.ready = (state_ff == ST_IDLE);

   // search token row
   assign tok_ctl[0].active = start_ff;
   assign tok_ctl[0].found  = 1'b0;
   assign tok_base[0]       = '0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffa_cell #(
         .IDX         (i),
         .ADDR_WIDTH  (ADDR_WIDTH),
         .COUNT_WIDTH (COUNT_WIDTH),
         .INDEX_WIDTH (INDEX_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op_ff),
         .req_size    (size_ff),
         .req_addr    (addr_ff),
         .entry_count (count_ff),
         .wr_en       (append),
         .wr_idx      (count_ff[INDEX_WIDTH-1:0]),
         .wr_base     (new_base),
         .wr_size     (size_ff),
         .tok_ctl_i   (tok_ctl[i]),
         .tok_base_i  (tok_base[i]),
         .tok_ctl_o   (tok_ctl[i+1]),
         .tok_base_o  (tok_base[i+1])
      );
   end

   for (genvar i = 0; i <= MAX_BLOCKS; i++) begin : g_act
      assign tok_act[i] = tok_ctl[i].active;
   end

   // append arithmetic
   assign end_w      = END_WIDTH'(heap_top_ff) + END_WIDTH'(HEADER_BYTES)
                       + END_WIDTH'(size_ff);
   assign fits       = (end_w[END_WIDTH-1:ADDR_WIDTH] == '0);
   assign table_full = (count_ff == COUNT_WIDTH'(MAX_BLOCKS));
   assign new_base   = heap_top_ff + ADDR_WIDTH'(HEADER_BYTES);
   assign append     = finish && !zero_free_ff && (op_ff == OP_ALLOC)
                       && !found_ff && !table_full && fits;

   always_comb begin
      res_addr   = '0;
      res_status = STATUS_OK;
      priority if (zero_free_ff) begin
         res_status = STATUS_OK;
      end else if (op_ff == OP_FREE) begin
         res_status = found_ff ? STATUS_OK : STATUS_UNKNOWN;
      end else if (found_ff) begin
         res_addr = hit_base_ff;
      end else if (table_full || !fits) begin
         res_status = STATUS_NOMEM;
      end else begin
         res_addr = new_base;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ((req_ch.opcode == OP_FREE) && (in_addr == '0))
                          ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_ctl[MAX_BLOCKS].active) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         heap_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept && !((req_ch.opcode == OP_FREE) && (in_addr == '0));
         if (append) begin
            count_ff    <= count_ff + COUNT_WIDTH'(1);
            heap_top_ff <= end_w[ADDR_WIDTH-1:0];
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_ch.opcode;
         size_ff      <= in_size;
         addr_ff      <= in_addr;
         zero_free_ff <= (req_ch.opcode == OP_FREE) && (in_addr == '0);
      end
      if ((state_ff == ST_SCAN) && tok_ctl[MAX_BLOCKS].active) begin
         found_ff    <= tok_ctl[MAX_BLOCKS].found;
         hit_base_ff <= tok_base[MAX_BLOCKS];
      end
      if (finish) begin
         rsp_addr_ff   <= FIELD_WIDTH'(res_addr);
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.address = rsp_addr_ff;
   assign rsp_ch.status  = rsp_status_ff;

   // checks
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_act))
      else $error("more than one search token in the row");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_ctl[MAX_BLOCKS].active |-> (state_ff == ST_SCAN))
      else $error("search token left the row outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(MAX_BLOCKS))
      else $error("entry count beyond table size");

   a_addr_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.address != '0)) |-> (rsp_ch.status == STATUS_OK))
      else $error("address granted with a failing status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.status == STATUS_OK) || (rsp_ch.status == STATUS_NOMEM)
                        || (rsp_ch.status == STATUS_UNKNOWN)))
      else $error("undefined status code");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the first-fit block allocator.
// ----------------------------------------------------------------------------
// A short directed sequence covers the field extremes and the corner cases:
// free of zero, unknown and double free, zero-size allocate, reuse, heap
// exhausted. Random requests follow, mostly frees of live blocks and
// allocates sized to hit reuse and the heap boundary. They run in phases
// with no idling, sender idling, receiver stalls and both.
// A shadow copy of the heap table predicts each response, and every item
// on the response channel is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
   import ffa_pkg::*;

   localparam int MAX_BLOCKS      = 16;
   localparam int ADDR_WIDTH      = 16;
   localparam int HEADER_BYTES    = 16;
   localparam int HEAP_LIMIT      = (1 << ADDR_WIDTH) - 1;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int DRAIN_CYCLES    = MAX_BLOCKS + 8;
   localparam int TIMEOUT_NS      = 2_000_000;

   typedef logic [FIELD_WIDTH-1:0] field_type;

   typedef struct packed {
      field_type               address;
      logic [STATUS_WIDTH-1:0] status;
   } grant_type;

   class heap_shadow;
      int        block_base[MAX_BLOCKS];
      int        block_bytes[MAX_BLOCKS];
      bit        block_free[MAX_BLOCKS];
      int        block_count;
      int        heap_top;
      grant_type expected_grants[$];
      int        mismatches;

      function new();
         block_count = 0;
         heap_top    = 0;
         mismatches  = 0;
      endfunction

      // bytes still free for a payload above the heap top
      function int room();
         return HEAP_LIMIT - heap_top - HEADER_BYTES;
      endfunction

      function grant_type serve(logic op, field_type size, field_type addr);
         grant_type g;
         int        i;
         int        payload;
         g.address = '0;
         g.status  = STATUS_OK;
         if (op == OP_ALLOC) begin
            for (i = 0; i < block_count; i++) begin
               if (block_free[i] && block_bytes[i] >= int'(size)) begin
                  block_free[i] = 1'b0;
                  g.address     = field_type'(block_base[i]);
                  return g;
               end
            end
            payload = heap_top + HEADER_BYTES;
            if (block_count >= MAX_BLOCKS || payload + int'(size) > HEAP_LIMIT) begin
               g.status = STATUS_NOMEM;
               return g;
            end
            block_base[block_count]  = payload;
            block_bytes[block_count] = int'(size);
            block_free[block_count]  = 1'b0;
            block_count++;
            heap_top  = payload + int'(size);
            g.address = field_type'(payload);
         end else if (addr != '0) begin
            for (i = 0; i < block_count; i++) begin
               if (block_base[i] == int'(addr)) begin
                  block_free[i] = 1'b1;
                  return g;
               end
            end
            g.status = STATUS_UNKNOWN;
         end
         return g;
      endfunction

      function void note_request(logic op, field_type size, field_type addr);
         expected_grants.push_back(serve(op, size, addr));
      endfunction

      function void check_grant(field_type address, logic [STATUS_WIDTH-1:0] status);
         grant_type want;
         if (expected_grants.size() == 0) begin
            $error("unexpected item: address %h status %0d", address, status);
            mismatches++;
            return;
         end
         want = expected_grants.pop_front();
         if (address !== want.address) begin
            $error("address: expected %h, actual %h", want.address, address);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   heap_shadow shadow = new();

   ffa_req_if req_ch ();
   ffa_rsp_if rsp_ch ();

   first_fit_block_allocator #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .ADDR_WIDTH   (ADDR_WIDTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_request(logic op, field_type size, field_type addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.request_size <= size;
      req_ch.free_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      shadow.note_request(op, size, addr);
   endtask

   task automatic send_random_request();
      logic      op;
      field_type size;
      field_type addr;
      int        pick;
      int        k;
      op   = ($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE;
      size = field_type'($urandom);
      addr = field_type'($urandom);
      pick = $urandom_range(99);
      k    = (shadow.block_count > 0) ? $urandom_range(shadow.block_count - 1) : 0;
      if (op == OP_ALLOC) begin
         if (pick < 55) begin
            size = field_type'($urandom_range(63));
         end else if (pick < 72) begin
            size = field_type'($urandom_range(4095));
         end else if (pick < 85 && shadow.block_count > 0) begin
            size = field_type'(shadow.block_bytes[k]);
         end else if (pick < 93) begin
            // just over the heap boundary, exact fit only for the last table slot
            if (shadow.room() >= 0) begin
               if (shadow.block_count == MAX_BLOCKS - 1)
                  size = field_type'(shadow.room() + $urandom_range(1));
               else
                  size = field_type'(shadow.room() + 1);
            end
         end else if (shadow.block_count < MAX_BLOCKS - 1 && int'(size) <= shadow.room()) begin
            // keep the heap from being eaten before the table fills
            size = 16'hFFF0 | field_type'($urandom_range(15));
         end
      end else begin
         if (pick < 70 && shadow.block_count > 0) begin
            addr = field_type'(shadow.block_base[k]);
         end else if (pick < 80) begin
            addr = '0;
         end else if (pick < 90 && shadow.block_count > 0) begin
            addr = field_type'(shadow.block_base[k] + 1 - 2 * int'($urandom_range(1)));
         end
      end
      send_request(op, size, addr);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         shadow.check_grant(rsp_ch.address, rsp_ch.status);
   end

   initial begin
      int phase;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_ALLOC;
      req_ch.request_size <= '0;
      req_ch.free_address <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_FREE, '0, '0);
      send_request(OP_FREE, '0, 16'hFFFF);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_ALLOC, 16'hFFFF, '0);
      send_request(OP_ALLOC, 16'd1, '0);
      send_request(OP_ALLOC, 16'd100, '0);
      send_request(OP_FREE, '0, field_type'(shadow.block_base[0]));
      send_request(OP_FREE, '0, field_type'(shadow.block_base[0]));
      send_request(OP_ALLOC, '0, 16'hFFFF);
      send_request(OP_FREE, 16'hFFFF, field_type'(shadow.block_base[1]));
      send_request(OP_ALLOC, 16'd2, '0);
      send_request(OP_ALLOC, 16'd1, '0);
      send_request(OP_FREE, '0, field_type'(shadow.block_base[2] + 1));
      send_request(OP_FREE, '0, 16'h8000);
      send_request(OP_ALLOC, field_type'(shadow.room() + 1), '0);
      send_request(OP_ALLOC, 16'h7FFF, '0);
      send_request(OP_FREE, '0, 16'h0001);
      send_request(OP_FREE, 16'hFFFF, '0);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 88;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 88;
            end
            default: begin
               send_idle_pct = 21;
               rsp_stall_pct = 21;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_request();
      end
      req_ch.valid <= 1'b0;

      while (shadow.expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
